// ===== sv/aldm_pkg.sv =====
// Package for the analog ladder matrix decoder.
// Holds the ladder level tables, the group layout and the record passed along the cell row.
// No dependencies.
package aldm_pkg;

   localparam int FIELD_CHANNELS = 4;
   localparam int MAX_GROUPS     = 2;
   localparam int SAMPLE_W       = 10;
   localparam int DIFF_W         = 12;
   localparam int MASTER_W       = 4;
   localparam int SLAVE_W        = 3;
   localparam int TABLE_LEVELS   = 10;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd16;

   localparam logic [0:0] REG_NOISE_THRESHOLD = 1'b0;

   localparam logic [6:0] CH0_LEVELS [0:TABLE_LEVELS-1] =
      '{7'd118, 7'd116, 7'd114, 7'd112, 7'd111, 7'd109, 7'd107, 7'd106, 7'd99, 7'd93};
   localparam logic [6:0] HIGH_LEVELS [0:TABLE_LEVELS-1] =
      '{7'd117, 7'd115, 7'd113, 7'd111, 7'd109, 7'd107, 7'd106, 7'd104, 7'd97, 7'd91};
   localparam logic [6:0] LOW_LEVELS [0:TABLE_LEVELS-1] =
      '{7'd64, 7'd58, 7'd52, 7'd48, 7'd44, 7'd41, 7'd39, 7'd36, 7'd28, 7'd23};

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [1:0]          chan;
      logic                found;
      logic                stopped;
      logic [DIFF_W-1:0]   prev;
      logic [MASTER_W-1:0] master;
      logic [SLAVE_W-1:0]  slave;
   } walk_type;

   function automatic logic [6:0] level_at(input logic [1:0] chan, input logic grp,
                                           input logic [3:0] lvl);
      logic [6:0] value;
      value = 7'd0;
      if (lvl < 4'(TABLE_LEVELS)) begin
         if (chan == 2'd0) begin
            value = grp ? 7'd0 : CH0_LEVELS[lvl];
         end else begin
            value = grp ? LOW_LEVELS[lvl] : HIGH_LEVELS[lvl];
         end
      end
      return value;
   endfunction

   function automatic logic [1:0] group_count(input logic [1:0] chan);
      return (chan == 2'd0) ? 2'd1 : 2'd2;
   endfunction

   function automatic logic [SLAVE_W-1:0] group_offset(input logic [1:0] chan);
      logic [SLAVE_W-1:0] offset;
      unique case (chan)
         2'd0: offset = 3'd0;
         2'd1: offset = 3'd1;
         2'd2: offset = 3'd3;
         2'd3: offset = 3'd5;
         default: offset = 3'd0;
      endcase
      return offset;
   endfunction

endpackage

// ===== sv/aldm_select.sv =====
// Front cell of the decoder row: picks the first channel above the noise threshold.
// Registers the chosen sample and channel for the walk cells.
// Depends on aldm_pkg.
module aldm_select #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  in_valid,
   output logic                                                  in_ready,
   input  logic [aldm_pkg::FIELD_CHANNELS-1:0][aldm_pkg::SAMPLE_W-1:0] samples,
   input  logic [aldm_pkg::SAMPLE_W-1:0]                         threshold,
   output logic                                                  out_valid,
   output aldm_pkg::walk_type                                    out_data,
   input  logic                                                  out_ready
);

   localparam int NCH_EFF = (NUM_CHANNELS > aldm_pkg::FIELD_CHANNELS) ?
                            aldm_pkg::FIELD_CHANNELS : NUM_CHANNELS;

   aldm_pkg::walk_type data_ff, data_in;
   logic               valid_ff;

   always_comb begin
      data_in = '0;
      for (int i = aldm_pkg::FIELD_CHANNELS - 1; i >= 0; i--) begin
         if (i < NCH_EFF && samples[i] > threshold) begin
            data_in.found = 1'b1;
            data_in.chan  = 2'(i);
         end
      end
      data_in.sample = samples[data_in.chan];
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== sv/aldm_cell.sv =====
// Walk cell of the decoder row: checks one ladder level of one group against the sample.
// Each cell holds one registered walk record and hands it to its neighbor.
// Depends on aldm_pkg.
module aldm_cell #(
   parameter int GRP         = 0,
   parameter int LVL         = 0,
   parameter int LEVEL_SCALE = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  aldm_pkg::walk_type in_data,
   output logic               in_ready,
   output logic               out_valid,
   output aldm_pkg::walk_type out_data,
   input  logic               out_ready
);

   localparam bit FIRST = (GRP == 0) && (LVL == 0);

   aldm_pkg::walk_type           data_ff, data_in;
   logic                         valid_ff;
   logic [aldm_pkg::DIFF_W-1:0]  level;
   logic [aldm_pkg::DIFF_W-1:0]  sample_ext;
   logic [aldm_pkg::DIFF_W-1:0]  diff;
   logic                         live;

   always_comb begin
      level = aldm_pkg::DIFF_W'(aldm_pkg::level_at(in_data.chan, 1'(GRP), 4'(LVL)))
              * aldm_pkg::DIFF_W'(LEVEL_SCALE);
      sample_ext = aldm_pkg::DIFF_W'(in_data.sample);
      diff = (level > sample_ext) ? (level - sample_ext) : (sample_ext - level);
      live = in_data.found && !in_data.stopped &&
             (2'(GRP) < aldm_pkg::group_count(in_data.chan));
      data_in = in_data;
      if (live) begin
         if (!FIRST && diff > in_data.prev) begin
            data_in.stopped = 1'b1;
         end else begin
            data_in.master = aldm_pkg::MASTER_W'(LVL + 1);
            data_in.slave  = aldm_pkg::group_offset(in_data.chan) +
                             aldm_pkg::SLAVE_W'(GRP + 1);
            data_in.prev   = diff;
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== sv/analog_ladder_matrix_decoder.sv =====
// Top level of the analog ladder matrix decoder: APB threshold register and the cell row.
// Instantiates aldm_select and one aldm_cell per ladder position; depends on aldm_pkg.
//
// Usage: each req transfer carries four 10-bit ADC samples, one per ladder channel. The
// first channel above the noise threshold is chosen and its level table is walked; the
// rsp transfer returns the 1-based master line and the slave line, both zero when no
// channel is above the threshold. Every req transfer yields exactly one rsp transfer, in
// order.
// Path: a result passes through the channel select cell and then through each walk cell
// of the row in order, each cell holding it in a register.
// Throughput: one transfer per cycle while rsp_stall is low; every cell of the row holds one item in flight.
// Stall: a stalled result holds on the rsp ports while the cells behind it keep moving
// into empty slots; req_stall rises only once every cell of the row is occupied.
// Reset empties the row and sets the noise threshold to 16. The threshold lies at byte
// address 0 of the APB port; the user writes it only while the block is idle (unchecked).
module analog_ladder_matrix_decoder #(
   parameter int NUM_CHANNELS     = 4,
   parameter int LEVELS_PER_GROUP = 10,
   parameter int LEVEL_SCALE      = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [9:0]  req_sample_ch0,
   input  logic [9:0]  req_sample_ch1,
   input  logic [9:0]  req_sample_ch2,
   input  logic [9:0]  req_sample_ch3,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_master_line,
   output logic [2:0]  rsp_slave_line,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int WALK_LEN   = aldm_pkg::MAX_GROUPS * LEVELS_PER_GROUP;
   localparam int NUM_STAGES = WALK_LEN + 1;

   logic [aldm_pkg::SAMPLE_W-1:0] threshold_ff;
   logic                          csr_write;
   logic [0:0]                    csr_index;

   logic [aldm_pkg::FIELD_CHANNELS-1:0][aldm_pkg::SAMPLE_W-1:0] samples;
   aldm_pkg::walk_type     stage_data  [0:WALK_LEN];
   logic [NUM_STAGES-1:0]  stage_valid;
   logic [NUM_STAGES:0]    stage_ready;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_index == aldm_pkg::REG_NOISE_THRESHOLD) ?
                       32'(threshold_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= aldm_pkg::THRESHOLD_RESET;
      end else if (csr_write && csr_index == aldm_pkg::REG_NOISE_THRESHOLD) begin
         threshold_ff <= csr_pwdata[aldm_pkg::SAMPLE_W-1:0];
      end
   end

   assign samples = {req_sample_ch3, req_sample_ch2, req_sample_ch1, req_sample_ch0};

   aldm_select #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (stage_ready[0]),
      .samples   (samples),
      .threshold (threshold_ff),
      .out_valid (stage_valid[0]),
      .out_data  (stage_data[0]),
      .out_ready (stage_ready[1])
   );

   for (genvar i = 0; i < WALK_LEN; i++) begin : g_cell
      aldm_cell #(
         .GRP         (i / LEVELS_PER_GROUP),
         .LVL         (i % LEVELS_PER_GROUP),
         .LEVEL_SCALE (LEVEL_SCALE)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_data   (stage_data[i]),
         .in_ready  (stage_ready[i+1]),
         .out_valid (stage_valid[i+1]),
         .out_data  (stage_data[i+1]),
         .out_ready (stage_ready[i+2])
      );
   end

   assign stage_ready[NUM_STAGES] = !rsp_stall;
   assign req_stall               = !stage_ready[0];
   assign rsp_valid               = stage_valid[NUM_STAGES-1];
   assign rsp_master_line         = stage_data[WALK_LEN].master;
   assign rsp_slave_line          = stage_data[WALK_LEN].slave;

`ifndef SYNTH
   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (stage_valid == {NUM_STAGES{1'b1}}))
      else $error("Request stalled while the cell row has an empty slot.");

   a_idle_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slave_line == 3'd0 |-> rsp_master_line == 4'd0)
      else $error("Result with no slave line carries a master line.");

   a_reset_empties_row: assert property (@(posedge clock)
      $past(reset) |-> (stage_valid == '0) && !rsp_valid)
      else $error("Cell row holds an item right after reset.");
`endif

endmodule
